// ----- rtl/core/sss_pkg.sv -----
// Shared types, constants and the digit segment table for the seven-segment scan driver.
package sss_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned POS_W      = $clog2(NUM_DIGITS);

    localparam logic [15:0]           PERIOD_RESET = 16'd19;
    localparam logic [NUM_DIGITS-1:0] SELECT_OFF   = '1;

    // reciprocal multipliers: floor(n * RECIP >> SHIFT) == n / divisor for any 16-bit n
    localparam logic [31:0] RECIP_10    = 32'd52429;
    localparam int unsigned SHIFT_10    = 19;
    localparam logic [33:0] RECIP_100   = 34'd167773;
    localparam int unsigned SHIFT_100   = 24;
    localparam logic [32:0] RECIP_1000  = 33'd67109;
    localparam int unsigned SHIFT_1000  = 26;
    localparam logic [32:0] RECIP_10000 = 33'd107375;
    localparam int unsigned SHIFT_10000 = 30;

    typedef struct packed {
        logic [12:0] q1;   // n / 10
        logic [9:0]  q2;   // n / 100
        logic [6:0]  q3;   // n / 1000
        logic [2:0]  q4;   // n / 10000
    } quot_t;

    typedef struct packed {
        logic load;
        logic tick;
    } scan_ctl_t;

    // stored code: bit 0 dot, bits 1..7 segments A..G
    typedef logic [NUM_DIGITS-1:0][7:0] codes_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0: code = 8'b0111_1110;
            4'd1: code = 8'b0000_1100;
            4'd2: code = 8'b1011_0110;
            4'd3: code = 8'b1001_1110;
            4'd4: code = 8'b1100_1100;
            4'd5: code = 8'b1101_1010;
            4'd6: code = 8'b1111_1010;
            4'd7: code = 8'b0000_1110;
            4'd8: code = 8'b1111_1110;
            4'd9: code = 8'b1101_1110;
            default: code = 8'b0000_0000;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/seven_segment_scan_driver.sv -----
// Four-digit multiplexed seven-segment scan driver, top level.
// Every input transfer yields exactly one result transfer carrying the drive
// outputs after that item. A load (s_tuser 0) converts the number into the
// codes of its low four decimal digits, blanking leading zeros except the
// ones digit, and lights the dot of digit dot_position when it is below 4;
// the drive outputs change only on the next advance. A tick (s_tuser 1)
// counts; after scan_period+1 ticks the scan moves to the next digit and
// drives its select line low with its segments. Until the first advance all
// selects are high and segments off. One register stage holds the decimal
// quotients, the second updates the scan state and the drive registers,
// which are the result register. One transfer is taken every cycle while
// the result side is ready. The user writes scan_period through cfg_wr_en/cfg_wr_data
// only while idle; the block itself does not enforce it.
module seven_segment_scan_driver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // number[15:0], dot_position[23:16]
    input  logic        s_tuser,    // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // digit_select_n[3:0], segments[11:4], shown_digit[13:12]
);

    logic                   en;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   s1_func_reg;
    logic [15:0]            s1_number_reg;
    logic [7:0]             s1_dot_reg;
    sss_pkg::quot_t         s1_quot_reg;
    sss_pkg::quot_t         quot;
    sss_pkg::codes_t        new_codes;
    sss_pkg::scan_ctl_t     ctl;
    logic [sss_pkg::NUM_DIGITS-1:0] select_drive;
    logic [7:0]                     segment_drive;
    logic [sss_pkg::POS_W-1:0]      scan_position;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    assign s1_valid_next = en ? s_tvalid : s1_valid_reg;
    assign m_valid_next  = en ? s1_valid_reg : m_valid_reg;

    assign ctl.load = en && s1_valid_reg && (s1_func_reg == sss_pkg::FUNC_LOAD);
    assign ctl.tick = en && s1_valid_reg && (s1_func_reg == sss_pkg::FUNC_TICK);

    sss_quot u_quot (
        .number (s_tdata[15:0]),
        .quot   (quot)
    );

    sss_codes u_codes (
        .number       (s1_number_reg),
        .dot_position (s1_dot_reg),
        .quot         (s1_quot_reg),
        .codes        (new_codes)
    );

    sss_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .ctl           (ctl),
        .new_codes     (new_codes),
        .select_drive  (select_drive),
        .segment_drive (segment_drive),
        .scan_position (scan_position)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_func_reg   <= s_tuser;
            s1_number_reg <= s_tdata[15:0];
            s1_dot_reg    <= s_tdata[23:16];
            s1_quot_reg   <= quot;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, scan_position, segment_drive, select_drive};

endmodule

// ----- rtl/core/sss_quot.sv -----
// Decimal quotients of a 16-bit number by reciprocal multiplication.
module sss_quot (
    input  logic [15:0]         number,
    output sss_pkg::quot_t      quot
);

    logic [31:0] prod_10;
    logic [33:0] prod_100;
    logic [32:0] prod_1000;
    logic [32:0] prod_10000;

    assign prod_10    = 32'(number) * sss_pkg::RECIP_10;
    assign prod_100   = 34'(number) * sss_pkg::RECIP_100;
    assign prod_1000  = 33'(number) * sss_pkg::RECIP_1000;
    assign prod_10000 = 33'(number) * sss_pkg::RECIP_10000;

    assign quot.q1 = prod_10[31:sss_pkg::SHIFT_10];
    assign quot.q2 = prod_100[33:sss_pkg::SHIFT_100];
    assign quot.q3 = prod_1000[32:sss_pkg::SHIFT_1000];
    assign quot.q4 = prod_10000[32:sss_pkg::SHIFT_10000];

endmodule

// ----- rtl/core/sss_codes.sv -----
// Digit extraction, leading-zero blanking and dot insertion for a load.
module sss_codes (
    input  logic [15:0]         number,
    input  logic [7:0]          dot_position,
    input  sss_pkg::quot_t      quot,
    output sss_pkg::codes_t     codes
);

    logic [15:0] ten_q1;
    logic [12:0] ten_q2;
    logic [9:0]  ten_q3;
    logic [6:0]  ten_q4;
    logic [15:0] rem0;
    logic [12:0] rem1;
    logic [9:0]  rem2;
    logic [6:0]  rem3;
    logic [3:0]  digit [sss_pkg::NUM_DIGITS];
    logic [sss_pkg::NUM_DIGITS-1:0] blank;
    logic        dot_on;

    assign ten_q1 = {quot.q1, 3'b000} + 16'({quot.q1, 1'b0});
    assign ten_q2 = 13'({quot.q2, 3'b000}) + 13'({quot.q2, 1'b0});
    assign ten_q3 = 10'({quot.q3, 3'b000}) + 10'({quot.q3, 1'b0});
    assign ten_q4 = 7'({quot.q4, 3'b000}) + 7'({quot.q4, 1'b0});

    assign rem0 = number - ten_q1;
    assign rem1 = quot.q1 - ten_q2;
    assign rem2 = quot.q2 - ten_q3;
    assign rem3 = quot.q3 - ten_q4;

    assign digit[0] = rem0[3:0];
    assign digit[1] = rem1[3:0];
    assign digit[2] = rem2[3:0];
    assign digit[3] = rem3[3:0];

    // ones digit always shown
    assign blank[0] = 1'b0;
    assign blank[1] = (quot.q1 == '0);
    assign blank[2] = (quot.q2 == '0);
    assign blank[3] = (quot.q3 == '0);

    assign dot_on = (dot_position < 8'(sss_pkg::NUM_DIGITS));

    always_comb begin
        for (int k = 0; k < sss_pkg::NUM_DIGITS; k++) begin
            codes[k] = blank[k] ? 8'h00 : sss_pkg::seg_code(digit[k]);
            if (dot_on && (dot_position[sss_pkg::POS_W-1:0] == sss_pkg::POS_W'(k))) begin
                codes[k][0] = 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/sss_scan.sv -----
// Digit code store, scan period register, tick counter and drive registers.
module sss_scan (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [15:0]                     cfg_wr_data,
    input  sss_pkg::scan_ctl_t              ctl,
    input  sss_pkg::codes_t                 new_codes,
    output logic [sss_pkg::NUM_DIGITS-1:0]  select_drive,
    output logic [7:0]                      segment_drive,
    output logic [sss_pkg::POS_W-1:0]       scan_position
);

    logic [15:0]                    period_reg;
    sss_pkg::codes_t                codes_reg, codes_next;
    logic [sss_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [15:0]                    count_reg, count_next;
    logic [sss_pkg::NUM_DIGITS-1:0] select_reg, select_next;
    logic [7:0]                     segment_reg, segment_next;
    logic [sss_pkg::POS_W-1:0]      pos_inc;
    logic [7:0]                     code_sel;

    assign pos_inc  = pos_reg + 1'b1;
    assign code_sel = codes_reg[pos_inc];

    always_comb begin
        codes_next   = codes_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        select_next  = select_reg;
        segment_next = segment_reg;
        if (ctl.load) begin
            codes_next = new_codes;
        end
        if (ctl.tick) begin
            if (count_reg >= period_reg) begin
                count_next   = '0;
                pos_next     = pos_inc;
                select_next  = ~(sss_pkg::NUM_DIGITS'(1) << pos_inc);
                segment_next = {code_sel[0], code_sel[7:1]};
            end else begin
                count_next = count_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= sss_pkg::PERIOD_RESET;
            codes_reg   <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            select_reg  <= sss_pkg::SELECT_OFF;
            segment_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            codes_reg   <= codes_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            select_reg  <= select_next;
            segment_reg <= segment_next;
        end
    end

    assign select_drive  = select_reg;
    assign segment_drive = segment_reg;
    assign scan_position = pos_reg;

endmodule

// ----- rtl/core/sss_checker.sv -----
// Port-level assertions for the scan driver, bound to the top level.
module sss_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_select_matches_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:0] != 4'hF)) |->
            (m_tdata[3:0] == ~(4'b0001 << m_tdata[13:12])))
        else $error("select line does not match shown digit");

    a_idle_display_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[3:0] == 4'hF)) |->
            ((m_tdata[11:4] == 8'h00) && (m_tdata[13:12] == 2'd0)))
        else $error("segments lit with no digit selected");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result transfer changed");

endmodule

bind seven_segment_scan_driver sss_checker u_sss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb.sv -----
// Self-checking testbench for the seven-segment scan driver: queued stimulus, scoreboard.
`timescale 1ns / 1ps

module tb;

    typedef enum {JOB_ITEM, JOB_SETTLE, JOB_PERIOD} job_kind_t;

    typedef struct {
        job_kind_t   kind;
        logic        func;
        logic [15:0] number;
        logic [7:0]  dot;
        logic [15:0] period;
        int unsigned gap;
    } scan_job_t;

    typedef struct packed {
        logic [3:0] sel;
        logic [7:0] seg;
        logic [1:0] pos;
    } drive_t;

    localparam logic [7:0] DIGIT_CODE [10] = '{8'h7E, 8'h0C, 8'hB6, 8'h9E, 8'hCC,
                                               8'hDA, 8'hFA, 8'h0E, 8'hFE, 8'hDE};
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 64;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;    // number[15:0], dot_position[23:16]
    logic        s_tuser     = 1'b0;  // func
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;             // digit_select_n[3:0], segments[11:4], shown_digit[13:12]

    scan_job_t scan_jobs [$];
    drive_t    drive_q [$];

    logic        s_taken = 1'b0;
    logic        m_taken = 1'b0;
    int          tx_gap  = 0;
    int          rx_wait = 0;
    bit          held    = 1'b0;
    bit          calm    = 1'b0;
    int          result_cnt = 0;
    int          fail_cnt   = 0;

    // scoreboard copy of the display state
    logic [15:0] mdl_period;
    logic [7:0]  mdl_codes [4];
    logic [1:0]  mdl_pos;
    logic [15:0] mdl_count;
    logic [3:0]  mdl_sel;
    logic [7:0]  mdl_seg;

    seven_segment_scan_driver u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic predict_drive(input logic func, input logic [15:0] num,
                                 input logic [7:0] dot, output drive_t res);
        int unsigned rest;
        int unsigned lim;
        logic [7:0]  code;
        if (func == sss_pkg::FUNC_LOAD) begin
            rest = num;
            lim  = 1;
            for (int k = 0; k < 4; k++) begin
                if (k > 0 && num < lim)
                    mdl_codes[k] = 8'h00;
                else
                    mdl_codes[k] = DIGIT_CODE[rest % 10];
                rest = rest / 10;
                lim  = lim * 10;
            end
            if (dot < 8'd4)
                mdl_codes[dot[1:0]][0] = 1'b1;
        end else if (mdl_count >= mdl_period) begin
            mdl_count = '0;
            mdl_pos   = mdl_pos + 2'd1;
            code      = mdl_codes[mdl_pos];
            mdl_sel   = ~(4'b0001 << mdl_pos);
            mdl_seg   = {code[0], code[7:1]};
        end else begin
            mdl_count = mdl_count + 16'd1;
        end
        res = '{sel: mdl_sel, seg: mdl_seg, pos: mdl_pos};
    endtask

    task automatic note_mismatch(input string what, input drive_t want, input drive_t got);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("%s: exp sel %h seg %h pos %0d, got sel %h seg %h pos %0d",
                     what, want.sel, want.seg, want.pos, got.sel, got.seg, got.pos);
    endtask

    // scoreboard: results checked, then accepted inputs predicted
    always @(posedge aclk) begin : check_proc
        drive_t want;
        drive_t got;
        if (!aresetn) begin
            mdl_period = sss_pkg::PERIOD_RESET;
            for (int k = 0; k < 4; k++)
                mdl_codes[k] = 8'h00;
            mdl_pos   = '0;
            mdl_count = '0;
            mdl_sel   = sss_pkg::SELECT_OFF;
            mdl_seg   = '0;
            s_taken <= 1'b0;
            m_taken <= 1'b0;
        end else begin
            if (cfg_wr_en)
                mdl_period = cfg_wr_data;
            if (m_tvalid && m_tready) begin
                got = '{sel: m_tdata[3:0], seg: m_tdata[11:4], pos: m_tdata[13:12]};
                result_cnt++;
                if (drive_q.size() == 0) begin
                    note_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = drive_q.pop_front();
                    if (want != got)
                        note_mismatch("drive mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                predict_drive(s_tuser, s_tdata[15:0], s_tdata[23:16], want);
                drive_q.push_back(want);
            end
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
        end
    end

    // sender
    always @(negedge aclk) begin : drive_proc
        logic nx_valid;
        logic nx_wr;
        nx_valid = s_tvalid;
        nx_wr    = 1'b0;
        if (!aresetn) begin
            nx_valid = 1'b0;
        end else if (s_tvalid && !s_taken) begin
            nx_valid = 1'b1;
        end else if (tx_gap > 0) begin
            nx_valid = 1'b0;
            tx_gap--;
        end else if (scan_jobs.size() == 0) begin
            nx_valid = 1'b0;
        end else begin
            nx_valid = 1'b0;
            case (scan_jobs[0].kind)
                JOB_SETTLE: begin
                    if (drive_q.size() == 0 && !s_taken)
                        void'(scan_jobs.pop_front());
                end
                JOB_PERIOD: begin
                    nx_wr = 1'b1;
                    cfg_wr_data <= scan_jobs[0].period;
                    void'(scan_jobs.pop_front());
                end
                default: begin
                    nx_valid = 1'b1;
                    s_tuser <= scan_jobs[0].func;
                    s_tdata <= {scan_jobs[0].dot, scan_jobs[0].number};
                    tx_gap = scan_jobs[0].gap;
                    void'(scan_jobs.pop_front());
                end
            endcase
        end
        s_tvalid  <= nx_valid;
        cfg_wr_en <= nx_wr;
    end

    // receiver, with one long hold-off so the pipeline backs up
    always @(negedge aclk) begin : ready_proc
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            m_tready <= 1'b0;
            rx_wait--;
        end else if (m_taken) begin
            if (!held && result_cnt >= HOLD_AFTER) begin
                held    = 1'b1;
                rx_wait = HOLD_CYCLES;
            end else if ((result_cnt / 48) % 3 == 0) begin
                rx_wait = 0;
            end else begin
                rx_wait = $urandom_range(0, 7);
            end
            m_tready <= (rx_wait == 0);
            if (rx_wait > 0)
                rx_wait--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic add_item(input logic func, input logic [15:0] num, input logic [7:0] dot);
        scan_job_t j;
        j.kind   = JOB_ITEM;
        j.func   = func;
        j.number = num;
        j.dot    = dot;
        j.period = '0;
        j.gap    = calm ? 0 : $urandom_range(0, 7);
        scan_jobs.push_back(j);
    endtask

    task automatic add_tick(input int n);
        for (int i = 0; i < n; i++)
            add_item(sss_pkg::FUNC_TICK, 16'($urandom), 8'($urandom));
    endtask

    // waits for every result before the write
    task automatic add_period(input logic [15:0] p);
        scan_job_t j;
        j.kind   = JOB_SETTLE;
        j.func   = sss_pkg::FUNC_LOAD;
        j.number = '0;
        j.dot    = '0;
        j.period = p;
        j.gap    = 0;
        scan_jobs.push_back(j);
        j.kind = JOB_PERIOD;
        scan_jobs.push_back(j);
    endtask

    initial begin : stim_proc
        logic [15:0] periods [7];
        logic [15:0] num;
        logic [7:0]  dot;

        // before first advance, then period lowered below the running count
        add_tick(1);
        add_item(sss_pkg::FUNC_LOAD, 16'd0, 8'd0);
        add_tick(3);
        add_period(16'd1);
        add_tick(1);
        add_item(sss_pkg::FUNC_LOAD, 16'd1234, 8'd0);
        add_tick(2);
        add_period(16'd0);
        add_tick(2);
        add_item(sss_pkg::FUNC_LOAD, 16'd65535, 8'd255);
        add_tick(4);
        add_item(sss_pkg::FUNC_LOAD, 16'd9, 8'd3);
        add_tick(2);
        add_item(sss_pkg::FUNC_LOAD, 16'd10, 8'd1);
        add_item(sss_pkg::FUNC_LOAD, 16'd100, 8'd2);
        add_item(sss_pkg::FUNC_LOAD, 16'd1000, 8'd4);
        add_item(sss_pkg::FUNC_LOAD, 16'd9999, 8'd128);
        add_tick(1);

        periods = '{16'd0, 16'd1, 16'd3, 16'd65535, 16'd2, 16'($urandom_range(0, 7)), 16'd0};
        foreach (periods[p]) begin
            add_period(periods[p]);
            for (int i = 0; i < 72; i++) begin
                if (i % 24 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 5))
                        0:       num = 16'($urandom_range(0, 9));
                        1:       num = 16'($urandom_range(0, 99));
                        2:       num = 16'($urandom_range(0, 999));
                        3:       num = 16'($urandom_range(0, 9999));
                        default: num = 16'($urandom_range(0, 65535));
                    endcase
                    dot = $urandom_range(0, 1) ? 8'($urandom_range(0, 4))
                                               : 8'($urandom_range(0, 255));
                    add_item(sss_pkg::FUNC_LOAD, num, dot);
                end else begin
                    add_tick(1);
                end
            end
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (scan_jobs.size() != 0 || s_tvalid || drive_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && drive_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : watchdog_proc
        #800_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sss_pkg.sv
rtl/core/sss_quot.sv
rtl/core/sss_codes.sv
rtl/core/sss_scan.sv
rtl/core/seven_segment_scan_driver.sv
rtl/core/sss_checker.sv
test/tb.sv
